// ===== rtl/pidc_pkg.sv =====
// Shared widths, register indexes, mode codes and the inter-stage term bundle.
package pidc_pkg;

    // Field and datapath widths
    localparam int GainW   = 32;
    localparam int ErrW    = 18;
    localparam int SumW    = 12;
    localparam int ProdPW  = 51;   // gain x 19-bit operand
    localparam int ProdIW  = 50;   // gain x 18-bit operand
    localparam int ProdDW  = 52;   // gain x 20-bit operand
    localparam int TotalW  = 54;   // sum of the three terms
    localparam int AccW    = 48;
    localparam int HeldW   = 33;   // |output| <= 65535 << 16
    localparam int DriveW  = 17;
    localparam int LimitW  = 16;
    localparam int FracBits = 16;

    // Measurement correction, deadband and error sum bound
    localparam logic [15:0] RawWrapThreshold = 16'd50000;
    localparam logic signed [ErrW-1:0] RawWrapOffset = 18'sd65533;
    localparam logic signed [ErrW-1:0] ErrDeadband   = 18'sd10;
    localparam int ErrSumLimit = 2000;

    // Configuration register indexes
    localparam logic [2:0] CfgPropGain   = 3'd0;
    localparam logic [2:0] CfgIntegGain  = 3'd1;
    localparam logic [2:0] CfgDerivGain  = 3'd2;
    localparam logic [2:0] CfgLoopMode   = 3'd3;
    localparam logic [2:0] CfgOutLimit   = 3'd4;
    localparam logic [2:0] CfgIntegLimit = 3'd5;

    // Loop modes; the other codes hold the last output
    localparam logic [1:0] ModePositional  = 2'd1;
    localparam logic [1:0] ModeIncremental = 2'd2;

    // Products handed from the error stage to the sum stage
    typedef struct packed {
        logic signed [ProdPW-1:0] p;
        logic signed [ProdIW-1:0] i;
        logic signed [ProdDW-1:0] d;
    } t_terms;

endpackage

// ===== rtl/pid_dual_mode_controller_core.sv =====
// Top level of the dual-mode PID controller: configuration registers, handshake and the two stages.
//
// Takes one measurement/setpoint beat per clock unless stalled and returns one drive beat for
// each. The first-stage register hands its beat to the drive register when the output is free.
// The first stage corrects the measurement, forms the deadbanded error, shifts the error
// history, updates the error sum and registers the three gain products at the accepting edge;
// the second stage clamps the integral term, sums the terms, updates the incremental accumulator
// and clamps and truncates the drive. Each recurrence (error history and sum in the first stage,
// accumulator and held output in the second) closes through its own register, so the rate is one
// beat per cycle while nothing stalls. A beat sits in the first stage while a finished drive
// waits, so input is stalled only when both stages are full and the output is stalled.
// Configuration writes are always ready and must be made while no beat is in flight.
module pid_dual_mode_controller_core
    import pidc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Configuration write channel
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [2:0]               i_cfg_index,
    input  logic [31:0]              i_cfg_data,
    // Input channel
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [15:0]              i_measured_raw,
    input  logic signed [15:0]       i_setpoint,
    // Output channel
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [DriveW-1:0] o_drive
);

    logic signed [GainW-1:0] r_prop_gain, r_integ_gain, r_deriv_gain;
    logic [1:0]              r_loop_mode;
    logic [LimitW-1:0]       r_output_limit, r_integ_limit;
    logic                    r_s1_valid, r_out_valid;

    logic   out_free, s1_adv, in_acc;
    t_terms terms;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain    <= '0;
            r_integ_gain   <= '0;
            r_deriv_gain   <= '0;
            r_loop_mode    <= ModePositional;
            r_output_limit <= '1;
            r_integ_limit  <= '1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CfgPropGain:   r_prop_gain    <= i_cfg_data;
                CfgIntegGain:  r_integ_gain   <= i_cfg_data;
                CfgDerivGain:  r_deriv_gain   <= i_cfg_data;
                CfgLoopMode:   r_loop_mode    <= i_cfg_data[1:0];
                CfgOutLimit:   r_output_limit <= i_cfg_data[LimitW-1:0];
                CfgIntegLimit: r_integ_limit  <= i_cfg_data[LimitW-1:0];
                default: begin
                end
            endcase
        end
    end

    // Two-slot flow control: output register plus first-stage register
    assign out_free    = !r_out_valid || !i_out_stall;
    assign s1_adv      = r_s1_valid && out_free;
    assign o_in_stall  = r_s1_valid && !out_free;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Stage one: error and products
    pidc_err_stage u_err (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (in_acc),
        .i_measured_raw (i_measured_raw),
        .i_setpoint     (i_setpoint),
        .i_loop_mode    (r_loop_mode),
        .i_prop_gain    (r_prop_gain),
        .i_integ_gain   (r_integ_gain),
        .i_deriv_gain   (r_deriv_gain),
        .o_terms        (terms)
    );

    // Stage two: sum, accumulate, clamp
    pidc_sum_stage u_sum (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (s1_adv),
        .i_terms        (terms),
        .i_loop_mode    (r_loop_mode),
        .i_output_limit (r_output_limit),
        .i_integ_limit  (r_integ_limit),
        .o_drive        (o_drive)
    );

endmodule

// ===== rtl/pidc_err_stage.sv =====
// Error stage: measurement correction, deadband, error history and the three gain products.
module pidc_err_stage
    import pidc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic [15:0]              i_measured_raw,
    input  logic signed [15:0]       i_setpoint,
    input  logic [1:0]               i_loop_mode,
    input  logic signed [GainW-1:0]  i_prop_gain,
    input  logic signed [GainW-1:0]  i_integ_gain,
    input  logic signed [GainW-1:0]  i_deriv_gain,
    output t_terms                   o_terms
);

    logic signed [ErrW-1:0] r_prev_err, r_prev_prev_err;
    logic signed [SumW-1:0] r_err_sum;
    t_terms                 r_terms, n_terms;

    logic signed [ErrW-1:0] meas, err_raw, err;
    logic signed [ErrW:0]   diff1, sum_full;
    logic signed [ErrW+1:0] diff2;
    logic signed [SumW-1:0] n_err_sum;
    logic signed [ErrW:0]   op_p;
    logic signed [ErrW-1:0] op_i;
    logic signed [ErrW+1:0] op_d;
    logic                   positional;

    // Corrected measurement and deadbanded error
    always_comb begin
        if (i_measured_raw > RawWrapThreshold) begin
            meas = $signed({2'b00, i_measured_raw}) - RawWrapOffset;
        end else begin
            meas = $signed({2'b00, i_measured_raw});
        end
        err_raw = {{(ErrW-16){i_setpoint[15]}}, i_setpoint} - meas;
        if (err_raw < ErrDeadband && err_raw > -ErrDeadband) begin
            err = '0;
        end else begin
            err = err_raw;
        end
    end

    // Differences and the clamped error sum
    always_comb begin
        diff1 = {err[ErrW-1], err} - {r_prev_err[ErrW-1], r_prev_err};
        diff2 = {{2{err[ErrW-1]}}, err}
              - {r_prev_err[ErrW-1], r_prev_err, 1'b0}
              + {{2{r_prev_prev_err[ErrW-1]}}, r_prev_prev_err};
        sum_full = {{(ErrW+1-SumW){r_err_sum[SumW-1]}}, r_err_sum}
                 + {err[ErrW-1], err};
        if (sum_full > (ErrW+1)'(ErrSumLimit)) begin
            n_err_sum = SumW'(ErrSumLimit);
        end else if (sum_full < -(ErrW+1)'(ErrSumLimit)) begin
            n_err_sum = -SumW'(ErrSumLimit);
        end else begin
            n_err_sum = sum_full[SumW-1:0];
        end
    end

    // Operand choice per mode, then one multiply per term
    assign positional = (i_loop_mode == ModePositional);

    always_comb begin
        if (positional) begin
            op_p = {err[ErrW-1], err};
            op_i = {{(ErrW-SumW){r_err_sum[SumW-1]}}, r_err_sum};
            op_d = {diff1[ErrW], diff1};
        end else begin
            op_p = diff1;
            op_i = err;
            op_d = diff2;
        end
        n_terms.p = i_prop_gain  * op_p;
        n_terms.i = i_integ_gain * op_i;
        n_terms.d = i_deriv_gain * op_d;
    end

    // Error history shifts on every accepted beat; the sum moves in positional mode only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_err      <= '0;
            r_prev_prev_err <= '0;
            r_err_sum       <= '0;
        end else if (i_en) begin
            r_prev_prev_err <= r_prev_err;
            r_prev_err      <= err;
            if (positional) begin
                r_err_sum <= n_err_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_terms <= n_terms;
        end
    end

    assign o_terms = r_terms;

endmodule

// ===== rtl/pidc_sum_stage.sv =====
// Sum stage: integral clamp, term sum, incremental accumulator, output clamp and truncation.
module pidc_sum_stage
    import pidc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  t_terms                   i_terms,
    input  logic [1:0]               i_loop_mode,
    input  logic [LimitW-1:0]        i_output_limit,
    input  logic [LimitW-1:0]        i_integ_limit,
    output logic signed [DriveW-1:0] o_drive
);

    logic signed [AccW-1:0]   r_acc, n_acc;
    logic signed [HeldW-1:0]  r_held, n_held;
    logic signed [DriveW-1:0] r_drive, n_drive;

    logic signed [ProdIW-1:0] ilim, it_c;
    logic signed [TotalW-1:0] olim_t, total, out_pos;
    logic signed [AccW-1:0]   olim_a, acc_sat, out_inc;
    logic signed [AccW+TotalW-AccW:0] acc_full;

    // Integral term clamp and the sum of the three terms
    always_comb begin
        ilim = $signed({{(ProdIW-LimitW-FracBits){1'b0}}, i_integ_limit, {FracBits{1'b0}}});
        if (i_terms.i > ilim) begin
            it_c = ilim;
        end else if (i_terms.i < -ilim) begin
            it_c = -ilim;
        end else begin
            it_c = i_terms.i;
        end
        total = {{(TotalW-ProdPW){i_terms.p[ProdPW-1]}}, i_terms.p}
              + {{(TotalW-ProdIW){it_c[ProdIW-1]}}, it_c}
              + {{(TotalW-ProdDW){i_terms.d[ProdDW-1]}}, i_terms.d};
    end

    // Positional output clamp
    always_comb begin
        olim_t = $signed({{(TotalW-LimitW-FracBits){1'b0}}, i_output_limit,
                          {FracBits{1'b0}}});
        if (total > olim_t) begin
            out_pos = olim_t;
        end else if (total < -olim_t) begin
            out_pos = -olim_t;
        end else begin
            out_pos = total;
        end
    end

    // Incremental accumulator saturates to its own width, then the output clamp
    always_comb begin
        acc_full = {{(TotalW+1-AccW){r_acc[AccW-1]}}, r_acc} + {total[TotalW-1], total};
        if (acc_full[TotalW:AccW-1] == '0 || acc_full[TotalW:AccW-1] == '1) begin
            acc_sat = acc_full[AccW-1:0];
        end else if (acc_full[TotalW]) begin
            acc_sat = {1'b1, {(AccW-1){1'b0}}};
        end else begin
            acc_sat = {1'b0, {(AccW-1){1'b1}}};
        end
        olim_a = $signed({{(AccW-LimitW-FracBits){1'b0}}, i_output_limit,
                          {FracBits{1'b0}}});
        if (acc_sat > olim_a) begin
            out_inc = olim_a;
        end else if (acc_sat < -olim_a) begin
            out_inc = -olim_a;
        end else begin
            out_inc = acc_sat;
        end
    end

    // Mode selection and truncation toward zero
    always_comb begin
        n_acc  = r_acc;
        n_held = r_held;
        case (i_loop_mode)
            ModePositional: begin
                n_held = out_pos[HeldW-1:0];
            end
            ModeIncremental: begin
                n_acc  = acc_sat;
                n_held = out_inc[HeldW-1:0];
            end
            default: begin
                n_held = r_held;
            end
        endcase
        n_drive = n_held[HeldW-1:FracBits]
                + DriveW'(n_held[HeldW-1] && (n_held[FracBits-1:0] != '0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_held <= '0;
        end else if (i_en) begin
            r_acc  <= n_acc;
            r_held <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_drive <= n_drive;
        end
    end

    assign o_drive = r_drive;

endmodule
